// ===== rtl/core/bbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrp_pkg
// Shared types and constants for the banked bitmap RAM port.
// ----------------------------------------------------------------------------
package bbrp_pkg;

   localparam int BANK_SHIFT = 13;
   localparam int ADDR_W     = 20;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   localparam logic [7:0] FIELD_4BPP = 8'h0f;
   localparam logic [7:0] FIELD_2BPP = 8'h03;

   localparam logic [4:0] RAM_BITS_RESET = 5'd18;

   // register index, byte address / 4
   localparam logic [2:0] REG_HOST_BANK   = 3'd0;
   localparam logic [2:0] REG_COPROC_BANK = 3'd1;
   localparam logic [2:0] REG_BITMAP_VIEW = 3'd2;
   localparam logic [2:0] REG_TWO_BPP     = 3'd3;
   localparam logic [2:0] REG_RAM_BITS    = 3'd4;

   typedef enum logic [1:0] {
      FUNC_HOST_RD = 2'd0,
      FUNC_HOST_WR = 2'd1,
      FUNC_COP_RD  = 2'd2,
      FUNC_COP_WR  = 2'd3
   } func_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [4:0] host_bank;
      logic [6:0] coproc_bank;
      logic       bitmap_view;
      logic       two_bpp;
      logic [4:0] ram_addr_bits;
   } cfg_type;

   // decoded access, held for the execute cycle
   typedef struct packed {
      logic       is_write;
      logic       is_pixel;
      logic       no_ram;
      logic [2:0] shift;
      logic [7:0] field;
   } acc_type;

endpackage

// ===== rtl/core/bbrp_ram.sv =====
// ----------------------------------------------------------------------------
// bbrp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bbrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bbrp_csr.sv =====
// ----------------------------------------------------------------------------
// bbrp_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bbrp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bbrp_pkg::CSR_AW-1:0]    paddr,
   input  logic [bbrp_pkg::CSR_DW-1:0]    pwdata,
   output logic [bbrp_pkg::CSR_DW-1:0]    prdata,
   output bbrp_pkg::cfg_type              cfg
);
   import bbrp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx = paddr[CSR_AW-1:2];
   assign wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_HOST_BANK:   cfg_in.host_bank     = pwdata[4:0];
            REG_COPROC_BANK: cfg_in.coproc_bank   = pwdata[6:0];
            REG_BITMAP_VIEW: cfg_in.bitmap_view   = pwdata[0];
            REG_TWO_BPP:     cfg_in.two_bpp       = pwdata[0];
            REG_RAM_BITS:    cfg_in.ram_addr_bits = pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_bank     <= '0;
         cfg_ff.coproc_bank   <= '0;
         cfg_ff.bitmap_view   <= 1'b0;
         cfg_ff.two_bpp       <= 1'b0;
         cfg_ff.ram_addr_bits <= RAM_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_HOST_BANK:   prdata = CSR_DW'(cfg_ff.host_bank);
         REG_COPROC_BANK: prdata = CSR_DW'(cfg_ff.coproc_bank);
         REG_BITMAP_VIEW: prdata = CSR_DW'(cfg_ff.bitmap_view);
         REG_TWO_BPP:     prdata = CSR_DW'(cfg_ff.two_bpp);
         REG_RAM_BITS:    prdata = CSR_DW'(cfg_ff.ram_addr_bits);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/bbrp_agu.sv =====
// ----------------------------------------------------------------------------
// bbrp_agu
// Address generation: bank mapping, pixel packing and RAM size wrap.
// ----------------------------------------------------------------------------
module bbrp_agu #(
   parameter int RAM_ADDR_WIDTH = 18
) (
   input  bbrp_pkg::cfg_type              cfg,
   input  logic [1:0]                     func,
   input  logic [bbrp_pkg::ADDR_W-1:0]    address,
   output logic [RAM_ADDR_WIDTH-1:0]      ram_addr,
   output bbrp_pkg::acc_type              acc
);
   import bbrp_pkg::*;

   logic [BANK_SHIFT-1:0]   offs;
   logic                    in_window;
   logic [ADDR_W-1:0]       host_full;
   logic [ADDR_W-1:0]       lin_full;
   logic [ADDR_W-1:0]       pix;
   logic [ADDR_W-1:0]       pix_byte;
   logic [ADDR_W-1:0]       full;
   logic [4:0]              bits_sat;
   logic [RAM_ADDR_WIDTH-1:0] mask;
   logic                    cop;

   assign offs      = address[BANK_SHIFT-1:0];
   assign in_window = (address[ADDR_W-1:BANK_SHIFT] == '0);
   assign host_full = in_window ? ADDR_W'({cfg.host_bank, offs}) : address;
   assign lin_full  = ADDR_W'({cfg.coproc_bank[4:0], offs});
   assign pix       = {cfg.coproc_bank, offs};
   assign pix_byte  = cfg.two_bpp ? (pix >> 2) : (pix >> 1);
   assign cop       = (func == FUNC_COP_RD) || (func == FUNC_COP_WR);

   always_comb begin
      if (!cop) begin
         full = host_full;
      end else if (cfg.bitmap_view) begin
         full = pix_byte;
      end else begin
         full = lin_full;
      end
   end

   // installed size saturates at the physical depth
   assign bits_sat = (cfg.ram_addr_bits > 5'(RAM_ADDR_WIDTH)) ?
                     5'(RAM_ADDR_WIDTH) : cfg.ram_addr_bits;

   always_comb begin
      for (int i = 0; i < RAM_ADDR_WIDTH; i++) begin
         mask[i] = (5'(i) < bits_sat);
      end
   end

   assign ram_addr = full[RAM_ADDR_WIDTH-1:0] & mask;

   always_comb begin
      acc.is_write = (func == FUNC_HOST_WR) || (func == FUNC_COP_WR);
      acc.is_pixel = cop && cfg.bitmap_view;
      acc.no_ram   = (cfg.ram_addr_bits == '0);
      if (cfg.two_bpp) begin
         acc.shift = {pix[1:0], 1'b0};
         acc.field = FIELD_2BPP;
      end else begin
         acc.shift = {pix[0], 2'b00};
         acc.field = FIELD_4BPP;
      end
   end

endmodule

// ===== rtl/core/banked_bitmap_ram_port.sv =====
// A read result shows on rsp_* from the result register: the RAM read is issued
//   when the item is taken, and the result is registered at the end of execute.
// busy is high for the execute cycle of every item, so a new item is taken only
//   once the last is done; a bitmap write puts its merged byte back in that cycle.
// Reset (synchronous, active high) clears the sequencer and the result strobe and
//   resets the CSRs; RAM contents are left as they are, undefined until written.
// ----------------------------------------------------------------------------
// banked_bitmap_ram_port
// Byte RAM shared by host and coprocessor, with banked and bitmap views.
// ----------------------------------------------------------------------------
module banked_bitmap_ram_port #(
   parameter int RAM_ADDR_WIDTH = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_func,
   input  logic [bbrp_pkg::ADDR_W-1:0]    req_address,
   input  logic [7:0]                     req_data,
   // result channel, one-cycle strobe, no back-pressure
   output logic                           rsp_valid,
   output logic [7:0]                     rsp_read_data,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bbrp_pkg::CSR_AW-1:0]    paddr,
   input  logic [bbrp_pkg::CSR_DW-1:0]    pwdata,
   output logic [bbrp_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);
   import bbrp_pkg::*;

   localparam int DEPTH = 1 << RAM_ADDR_WIDTH;

   cfg_type                   cfg;
   acc_type                   acc_new;
   logic [RAM_ADDR_WIDTH-1:0] addr_new;

   state_type                 state_ff, state_in;
   acc_type                   acc_ff;
   logic [RAM_ADDR_WIDTH-1:0] addr_ff;
   logic [7:0]                data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      ram_en;
   logic                      ram_we;
   logic [RAM_ADDR_WIDTH-1:0] ram_addr;
   logic [7:0]                ram_wdata;
   logic [7:0]                ram_rdata;
   logic [7:0]                pix_rd;
   logic [7:0]                merged;

   assign pready = 1'b1;

   bbrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   bbrp_agu #(
      .RAM_ADDR_WIDTH (RAM_ADDR_WIDTH)
   ) u_agu (
      .cfg      (cfg),
      .func     (req_func),
      .address  (req_address),
      .ram_addr (addr_new),
      .acc      (acc_new)
   );

   bbrp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // ---- sequencer: IDLE takes an item and reads, EXEC finishes it ----
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = (start) ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
            ram_en = start;                 // read for every item, used or not
            ram_we = 1'b0;
         end
         ST_EXEC: begin
            busy   = 1'b1;
            accept = 1'b0;
            ram_en = acc_ff.is_write && !acc_ff.no_ram;
            ram_we = acc_ff.is_write && !acc_ff.no_ram;
         end
         default: begin
            busy   = 1'b1;
            accept = 1'b0;
            ram_en = 1'b0;
            ram_we = 1'b0;
         end
      endcase
   end

   assign ram_addr = (state_ff == ST_EXEC) ? addr_ff : addr_new;

   // ---- datapath in the execute cycle: RAM data is valid here ----
   assign pix_rd = (ram_rdata >> acc_ff.shift) & acc_ff.field;
   assign merged = (ram_rdata & ~(acc_ff.field << acc_ff.shift)) |
                   ((data_ff & acc_ff.field) << acc_ff.shift);

   assign ram_wdata = acc_ff.is_pixel ? merged : data_ff;

   always_comb begin
      rsp_valid_in = (state_ff == ST_EXEC) && !acc_ff.is_write;
      if (acc_ff.no_ram) begin
         // open bus for bytes; a bitmap read sees a zero byte
         rsp_data_in = acc_ff.is_pixel ? 8'h00 : data_ff;
      end else begin
         rsp_data_in = acc_ff.is_pixel ? pix_rd : ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff  <= acc_new;
         addr_ff <= addr_new;
         data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ---- checks ----
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execute");

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_IDLE))
      else $error("execute held longer than one cycle");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_EXEC))
      else $error("result strobe without an execute cycle");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(ram_we))
      else $error("RAM written while finishing a read");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for banked_bitmap_ram_port. Items go in on the command
// channel and configuration goes through the register port. A shadow of the
// RAM and of the registers predicts every read result. Each strobed result is
// compared with the oldest pending read. Directed items come first, then
// random phases, each under its own register setting.
// ----------------------------------------------------------------------------
module tb_top;
   import bbrp_pkg::*;

   localparam int RAM_AW         = 18;
   localparam int RAM_DEPTH      = 1 << RAM_AW;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 200;
   localparam int MAX_REPORTS    = 10;

   // one read still to come back, kept whole for the error report
   typedef struct {
      func_type    func;
      logic [19:0] address;
      logic [7:0]  data;
      logic [7:0]  read_data;
   } pending_read_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_func;
   logic [ADDR_W-1:0]   req_address;
   logic [7:0]          req_data;
   logic                rsp_valid;
   logic [7:0]          rsp_read_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   // shadow of the block: registers, RAM bytes, and which bytes hold data
   cfg_type             cfg;
   bit [7:0]            ram_image   [RAM_DEPTH];
   bit                  ram_written [RAM_DEPTH];

   pending_read_type    pending_reads [$];
   pending_read_type    oldest;
   int                  mismatch_count;
   int                  idle_count;
   int                  burst_left;
   bit                  gaps_on;

   logic [2:0]          reg_list [5] = '{REG_HOST_BANK, REG_COPROC_BANK, REG_BITMAP_VIEW,
                                         REG_TWO_BPP, REG_RAM_BITS};

   banked_bitmap_ram_port #(
      .RAM_ADDR_WIDTH (RAM_AW)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_address   (req_address),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Address mapping of the shadow: gives the RAM byte an access touches and,
   // for bitmap pixels, the bit position and field mask within that byte.
   // -------------------------------------------------------------------------
   function automatic void map_access(input func_type f, input logic [ADDR_W-1:0] a,
                                      output int unsigned loc, output bit pixel,
                                      output int unsigned sh, output logic [7:0] fld);
      int unsigned ofs;
      int unsigned ea;
      int unsigned pix;
      int unsigned bits;
      ofs   = 32'(a[BANK_SHIFT-1:0]);
      pixel = 1'b0;
      sh    = 0;
      fld   = 8'hff;
      if (f == FUNC_HOST_RD || f == FUNC_HOST_WR) begin
         // host window below 8 KiB, pass-through above
         ea = (a < (20'd1 << BANK_SHIFT)) ? ((32'(cfg.host_bank) << BANK_SHIFT) + ofs)
                                          : 32'(a);
      end else if (!cfg.bitmap_view) begin
         // linear view only sees the low five bank bits
         ea = (32'(cfg.coproc_bank[4:0]) << BANK_SHIFT) + ofs;
      end else begin
         pix   = (32'(cfg.coproc_bank) << BANK_SHIFT) + ofs;
         pixel = 1'b1;
         if (!cfg.two_bpp) begin
            ea  = pix >> 1;
            sh  = (pix & 1) * 4;
            fld = FIELD_4BPP;
         end else begin
            ea  = pix >> 2;
            sh  = (pix & 3) * 2;
            fld = FIELD_2BPP;
         end
      end
      // oversized RAM setting saturates at the built depth
      bits = (cfg.ram_addr_bits > RAM_AW) ? RAM_AW : 32'(cfg.ram_addr_bits);
      loc  = ea & ((32'd1 << bits) - 1);
   endfunction

   // Applies one item to the shadow; returns 1 with the read byte for reads.
   function automatic bit predict_access(input func_type f, input logic [ADDR_W-1:0] a,
                                         input logic [7:0] d, output logic [7:0] rd);
      int unsigned loc;
      int unsigned sh;
      bit          pixel;
      bit          no_ram;
      logic [7:0]  fld;
      logic [7:0]  cur;
      logic [7:0]  sel_mask;
      map_access(f, a, loc, pixel, sh, fld);
      no_ram = (cfg.ram_addr_bits == 0);
      // no RAM fitted: pixel reads see a zero byte
      cur    = no_ram ? 8'h00 : ram_image[loc];
      rd     = 8'h00;
      if (f == FUNC_HOST_RD || f == FUNC_COP_RD) begin
         if (pixel)
            rd = (cur >> sh) & fld;
         else
            rd = no_ram ? d : cur;
         return 1'b1;
      end
      if (!no_ram) begin
         sel_mask          = fld << sh;
         ram_image[loc]    = pixel ? ((cur & ~sel_mask) | 8'((d & fld) << sh)) : d;
         ram_written[loc]  = 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic note_error(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s: expected %h, got %h", $time, what, exp_v, got_v);
   endtask

   // -------------------------------------------------------------------------
   // Command channel. Fields change at the falling edge; the item is taken at
   // the first rising edge where busy is low. The prediction is made there.
   // -------------------------------------------------------------------------
   task automatic drive_item(input func_type f, input logic [ADDR_W-1:0] a,
                             input logic [7:0] d);
      pending_read_type chk;
      logic [7:0]       rd;
      @(negedge clock);
      start       <= 1'b1;
      req_func    <= f;
      req_address <= a;
      req_data    <= d;
      do @(posedge clock); while (busy);
      if (predict_access(f, a, d, rd)) begin
         chk = '{f, a, d, rd};
         pending_reads.push_back(chk);
      end
   endtask

   // Sends one item. An access that would read a RAM byte with no data yet
   // (reads, and the read half of a pixel write) is preceded by a host write
   // to that byte: bit 18 keeps the address above the window and masks away.
   task automatic send_item(input func_type f, input logic [ADDR_W-1:0] a,
                            input logic [7:0] d);
      int unsigned loc;
      int unsigned sh;
      bit          pixel;
      logic [7:0]  fld;
      map_access(f, a, loc, pixel, sh, fld);
      if (cfg.ram_addr_bits != 0 && !ram_written[loc] &&
          (f == FUNC_HOST_RD || f == FUNC_COP_RD || (f == FUNC_COP_WR && pixel)))
         drive_item(FUNC_HOST_WR, 20'h40000 | 20'(loc), 8'($urandom));
      drive_item(f, a, d);
   endtask

   // start low with junk on the fields
   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         start       <= 1'b0;
         req_func    <= 2'($urandom);
         req_address <= 20'($urandom);
         req_data    <= 8'($urandom);
      end
   endtask

   task automatic pace_sender();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         if (gaps_on)
            idle_sender($urandom_range(1, 8));
      end
   endtask

   // Idle point for register writes: every read back, nothing in flight
   // (a write gives no result, so wait out busy and the pipeline too).
   task automatic drain_items();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register port: setup cycle, access cycle, done when pready is seen.
   // -------------------------------------------------------------------------
   task automatic csr_access(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
      case (idx)
         REG_HOST_BANK:   return 32'(cfg.host_bank);
         REG_COPROC_BANK: return 32'(cfg.coproc_bank);
         REG_BITMAP_VIEW: return 32'(cfg.bitmap_view);
         REG_TWO_BPP:     return 32'(cfg.two_bpp);
         REG_RAM_BITS:    return 32'(cfg.ram_addr_bits);
         default:         return 32'h0;
      endcase
   endfunction

   task automatic check_reg(input logic [2:0] idx);
      logic [31:0] got;
      csr_access(idx, 1'b0, 32'h0, got);
      if (got !== shadow_reg(idx))
         note_error($sformatf("register %0d readback", idx), shadow_reg(idx), got);
   endtask

   // write, mirror the field (upper bits dropped), read back
   task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] got;
      csr_access(idx, 1'b1, value, got);
      case (idx)
         REG_HOST_BANK:   cfg.host_bank     = value[4:0];
         REG_COPROC_BANK: cfg.coproc_bank   = value[6:0];
         REG_BITMAP_VIEW: cfg.bitmap_view   = value[0];
         REG_TWO_BPP:     cfg.two_bpp       = value[0];
         REG_RAM_BITS:    cfg.ram_addr_bits = value[4:0];
         default: ;
      endcase
      check_reg(idx);
   endtask

   task automatic configure(input logic [4:0] hb, input logic [6:0] cb, input bit bv,
                            input bit b2, input logic [4:0] bits);
      drain_items();
      set_reg(REG_HOST_BANK, 32'(hb));
      set_reg(REG_COPROC_BANK, 32'(cb));
      set_reg(REG_BITMAP_VIEW, 32'(bv));
      set_reg(REG_TWO_BPP, 32'(b2));
      set_reg(REG_RAM_BITS, 32'(bits));
   endtask

   // -------------------------------------------------------------------------
   // Result check: one strobe, one pending read, compared in order.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_reads.size() == 0) begin
            note_error("result with no read pending", 32'h0, 32'(rsp_read_data));
         end else begin
            oldest = pending_reads.pop_front();
            if (rsp_read_data !== oldest.read_data)
               note_error($sformatf("read_data, %s addr %h data %h", oldest.func.name(),
                                    oldest.address, oldest.data),
                          32'(oldest.read_data), 32'(rsp_read_data));
         end
      end
   end

   // progress watchdog: any handshake on either port counts
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // reset values, then all ones (upper bits must drop) and all zeros
   task automatic test_registers();
      foreach (reg_list[i])
         check_reg(reg_list[i]);
      foreach (reg_list[i]) begin
         set_reg(reg_list[i], 32'hffff_ffff);
         set_reg(reg_list[i], 32'h0);
      end
   endtask

   // window in the top bank, both window edges, pass-through at the top
   task automatic test_host_window();
      configure(5'd31, 7'd0, 1'b0, 1'b0, 5'd18);
      send_item(FUNC_HOST_WR, 20'h00000, 8'hff);
      send_item(FUNC_HOST_WR, 20'h01fff, 8'h00);
      send_item(FUNC_HOST_RD, 20'h00000, 8'h00);
      send_item(FUNC_HOST_WR, 20'hfffff, 8'ha5);
      send_item(FUNC_HOST_RD, 20'h01fff, 8'hff);
      send_item(FUNC_HOST_RD, 20'h02000, 8'h5a);
   endtask

   // linear view drops bank bits 5 and 6 and address bits above the window
   task automatic test_linear_view();
      configure(5'd0, 7'd127, 1'b0, 1'b0, 5'd18);
      send_item(FUNC_COP_WR, 20'hfe000, 8'h5a);
      send_item(FUNC_COP_RD, 20'h00000, 8'hff);
      send_item(FUNC_COP_RD, 20'h01fff, 8'h00);
   endtask

   // both nibbles, then crumbs 0, 2 and 3; only the low data bits are used
   task automatic test_bitmap();
      configure(5'd0, 7'd127, 1'b1, 1'b0, 5'd18);
      send_item(FUNC_COP_WR, 20'h01ffe, 8'hff);
      send_item(FUNC_COP_WR, 20'h01fff, 8'h03);
      send_item(FUNC_COP_RD, 20'h01ffe, 8'h00);
      send_item(FUNC_COP_RD, 20'h01fff, 8'h00);
      configure(5'd0, 7'd127, 1'b1, 1'b1, 5'd18);
      send_item(FUNC_COP_WR, 20'h00000, 8'hff);
      send_item(FUNC_COP_WR, 20'h00003, 8'hfe);
      send_item(FUNC_COP_RD, 20'h00000, 8'h00);
      send_item(FUNC_COP_RD, 20'h00002, 8'h00);
      send_item(FUNC_COP_RD, 20'h00003, 8'h00);
   endtask

   // no RAM: open bus on byte reads, zero pixels, writes dropped
   task automatic test_no_ram();
      configure(5'd31, 7'd0, 1'b0, 1'b0, 5'd0);
      send_item(FUNC_HOST_WR, 20'h00000, 8'h11);
      send_item(FUNC_HOST_RD, 20'h01234, 8'hc3);
      send_item(FUNC_COP_RD, 20'h00000, 8'h7e);
      configure(5'd31, 7'd127, 1'b1, 1'b0, 5'd0);
      send_item(FUNC_COP_WR, 20'h01ffe, 8'h00);
      send_item(FUNC_COP_RD, 20'h01ffe, 8'hff);
      configure(5'd31, 7'd0, 1'b0, 1'b0, 5'd18);
      send_item(FUNC_HOST_RD, 20'h00000, 8'h00);
   endtask

   // oversized setting saturates; a two-byte RAM wraps hard
   task automatic test_ram_size();
      configure(5'd0, 7'd0, 1'b0, 1'b0, 5'd31);
      send_item(FUNC_HOST_RD, 20'h01fff, 8'h00);
      configure(5'd0, 7'd0, 1'b0, 1'b0, 5'd1);
      send_item(FUNC_HOST_WR, 20'h02001, 8'h42);
      send_item(FUNC_HOST_RD, 20'h00003, 8'h00);
   endtask

   function automatic logic [4:0] pick_ram_bits();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return 5'($urandom_range(19, 31));
         2:       return 5'($urandom_range(1, 12));
         default: return 5'($urandom_range(13, 18));
      endcase
   endfunction

   // Addresses crowd into a few hot offsets and banks so that reads mostly
   // find data; a share is fully random to toggle every address bit.
   task automatic send_random_item();
      func_type          f;
      logic [ADDR_W-1:0] a;
      logic [7:0]        d;
      logic [12:0]       ofs;
      logic [6:0]        hi;
      f   = func_type'($urandom_range(0, 3));
      ofs = $urandom_range(0, 1) ? 13'($urandom_range(0, 31))
                                 : 13'(13'h1fe0 + $urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0, 1: begin
            hi  = 7'($urandom);
            ofs = 13'($urandom);
         end
         2, 3, 4, 5: hi = 7'h00;
         default:    hi = $urandom_range(0, 1) ? 7'h7f : 7'($urandom_range(1, 3));
      endcase
      a = {hi, ofs};
      case ($urandom_range(0, 7))
         0:       d = 8'h00;
         1:       d = 8'hff;
         default: d = 8'($urandom);
      endcase
      send_item(f, a, d);
      pace_sender();
   endtask

   // first phases pin the extremes, the rest draw settings at random
   task automatic test_random();
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(5'd31, 7'd127, 1'b1, 1'b0, 5'd18);
            1: configure(5'd0, 7'd0, 1'b0, 1'b1, 5'd1);
            2: configure(5'($urandom), 7'($urandom), 1'b1, 1'b1, 5'd0);
            default: configure($urandom_range(0, 2) == 0 ? 5'd31 : 5'($urandom),
                               $urandom_range(0, 2) == 0 ? 7'd127 : 7'($urandom),
                               1'($urandom), 1'($urandom), pick_ram_bits());
         endcase
         gaps_on    = (p % 4 != 3);
         burst_left = 0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_HOST_RD;
      req_address    = '0;
      req_data       = 8'h00;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      mismatch_count = 0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      cfg            = '{host_bank: 5'd0, coproc_bank: 7'd0, bitmap_view: 1'b0,
                         two_bpp: 1'b0, ram_addr_bits: RAM_BITS_RESET};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_registers();
      test_host_window();
      test_linear_view();
      test_bitmap();
      test_no_ram();
      test_ram_size();
      test_random();

      drain_items();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
